FILE: rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants of the indexed LIFO stack
// Beat payloads, operation and status codes, and the per-cell command that
// the top level hands to each stack cell.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

   // Stack geometry
   localparam int DEPTH      = 64;
   localparam int DATA_W     = 32;
   localparam int POS_W      = 8;
   localparam int OP_W       = 3;
   localparam int STATUS_W   = 2;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   // Read tree: first level ORs groups of this many cells
   localparam int GROUP_SIZE = 8;
   localparam int NUM_GROUPS = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

   // Operation codes
   localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OP_W-1:0] OP_POP    = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
   localparam logic [OP_W-1:0] OP_PEEK   = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // Cell commands
   localparam logic [1:0] CELL_HOLD  = 2'd0;  // keep contents
   localparam logic [1:0] CELL_OPEN  = 2'd1;  // open a gap at target, load value
   localparam logic [1:0] CELL_CLOSE = 2'd2;  // close the gap at target

   typedef struct packed {
      logic [OP_W-1:0]          operation;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
   } req_beat_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [STATUS_W-1:0]      status;
      logic [CNT_W-1:0]         occupancy;
   } rsp_beat_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [IDX_W-1:0] target;
      logic             read_en;
   } cell_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell: one stack entry
// Holds the word at a fixed distance from the top. On an open it takes the
// word of the neighbor above (or the new value at the target); on a close it
// takes the word of the neighbor below. Drives its word onto the read tree
// when it is the read target.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_cell (
   input  wire logic                      clock,
   input  wire logic [ils_pkg::IDX_W-1:0]  cell_index,
   input  wire ils_pkg::cell_cmd_type      cmd,
   input  wire logic [ils_pkg::DATA_W-1:0] value_in,
   input  wire logic [ils_pkg::DATA_W-1:0] prev_data,
   input  wire logic [ils_pkg::DATA_W-1:0] next_data,
   output logic      [ils_pkg::DATA_W-1:0] data,
   output logic      [ils_pkg::DATA_W-1:0] read_word
);
   import ils_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              below;
   logic              at_target;

   // Place this cell relative to the target position
   assign below     = (cell_index < cmd.target);
   assign at_target = (cell_index == cmd.target);

   // Select the next word
   always_comb begin
      data_in = data_ff;
      unique case (cmd.kind)
         CELL_OPEN: begin
            if (at_target) begin
               data_in = value_in;
            end else if (!below) begin
               data_in = prev_data;
            end
         end
         CELL_CLOSE: begin
            if (!below) begin
               data_in = next_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // Hold the word
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign read_word = (cmd.read_en && at_target) ? data_ff : '0;

endmodule

`default_nettype wire

FILE: rtl/ils_read_tree.sv
// ----------------------------------------------------------------------------
// ils_read_tree: first level of the read OR tree
// ORs the masked cell words in groups and registers the group results. At
// most one cell drives a nonzero word, so the OR picks out that word.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_read_tree (
   input  wire logic                      clock,
   input  wire logic                      load,
   input  wire logic [ils_pkg::DATA_W-1:0] words [ils_pkg::DEPTH],
   output logic      [ils_pkg::DATA_W-1:0] group_or_ff [ils_pkg::NUM_GROUPS]
);
   import ils_pkg::*;

   logic [DATA_W-1:0] group_or_in [NUM_GROUPS];

   // OR each group of cells
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_or_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < DEPTH) begin
               group_or_in[g] = group_or_in[g] | words[g * GROUP_SIZE + k];
            end
         end
      end
   end

   // Capture on an accepted beat
   always_ff @(posedge clock) begin
      if (load) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            group_or_ff[g] <= group_or_in[g];
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/indexed_lifo_stack_top.sv
// ----------------------------------------------------------------------------
// indexed_lifo_stack_top: bounded stack of signed words with indexed access
// Push, pop, insert, remove, peek and clear on a row of register cells.
// ----------------------------------------------------------------------------
// The stack is a row of DEPTH register cells, cell 0 holding the top. Every
// operation updates all cells in parallel in the cycle it is accepted (each
// cell holds, loads, or copies a neighbor), so one request beat can be taken
// every clock cycle while the request side does not stall. The word read by
// pop, remove or peek goes through a two-level OR tree: the first level is
// registered at the edge that accepts the request, the second feeds the
// response register, which takes the tree stage's beat when it is free or its
// own beat is taken. The request side stalls only while both the tree stage
// and the response register hold beats and the response side stalls.
`default_nettype none

module indexed_lifo_stack_top (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire ils_pkg::req_beat_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output ils_pkg::rsp_beat_type      rsp_data
);
   import ils_pkg::*;

   logic                req_accept;
   logic                out_ready;
   logic                s1_move;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [STATUS_W-1:0] status_in;
   cell_cmd_type        cmd;

   logic                s1_valid_ff;
   logic [STATUS_W-1:0] s1_status_ff;
   logic [CNT_W-1:0]    s1_count_ff;

   logic                rsp_valid_ff;
   rsp_beat_type        rsp_data_ff;

   logic [DATA_W-1:0]   cell_data [DEPTH];
   logic [DATA_W-1:0]   cell_read [DEPTH];
   logic [DATA_W-1:0]   group_or [NUM_GROUPS];
   logic [DATA_W-1:0]   read_or;

   logic [CNT_W-1:0]    last_cnt;
   logic [CMP_W-1:0]    pos_c;
   logic [CMP_W-1:0]    n_c;
   logic [CMP_W-1:0]    last_c;

   // Handshake: the tree stage advances when the response register is free
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && out_ready;
   assign req_stall  = s1_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;

   // Widen the position and count for clipping
   assign last_cnt = count_ff - CNT_W'(1);
   assign pos_c    = CMP_W'(req_data.position);
   assign n_c      = CMP_W'(count_ff);
   assign last_c   = CMP_W'(last_cnt);

   // Decode the operation into a cell command, status and new count
   always_comb begin
      cmd.kind    = CELL_HOLD;
      cmd.target  = '0;
      cmd.read_en = 1'b0;
      status_in   = ST_OK;
      count_in    = count_ff;
      if (req_accept) begin
         unique case (req_data.operation)
            OP_PUSH: begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  status_in = ST_FULL;
               end else begin
                  cmd.kind = CELL_OPEN;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_POP: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  cmd.kind    = CELL_CLOSE;
                  cmd.read_en = 1'b1;
                  count_in    = last_cnt;
               end
            end
            OP_INSERT: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else if (count_ff == CNT_W'(DEPTH)) begin
                  status_in = ST_FULL;
               end else begin
                  cmd.kind = CELL_OPEN;
                  // zero or past the bottom means below the last entry
                  if (pos_c == '0 || pos_c > n_c) begin
                     cmd.target = IDX_W'(count_ff);
                  end else begin
                     cmd.target = IDX_W'(req_data.position);
                  end
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_REMOVE: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  cmd.kind    = CELL_CLOSE;
                  cmd.read_en = 1'b1;
                  // zero or past the bottom means the bottom entry
                  if (pos_c == '0 || pos_c > last_c) begin
                     cmd.target = IDX_W'(last_cnt);
                  end else begin
                     cmd.target = IDX_W'(req_data.position);
                  end
                  count_in = last_cnt;
               end
            end
            OP_PEEK: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  cmd.read_en = 1'b1;
                  if (pos_c > last_c) begin
                     cmd.target = IDX_W'(last_cnt);
                  end else begin
                     cmd.target = IDX_W'(req_data.position);
                  end
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   // Row of stack cells, cell 0 at the top
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_W-1:0] prev_word;
      logic [DATA_W-1:0] next_word;

      if (g == 0) begin : g_first
         assign prev_word = '0;
      end else begin : g_inner_prev
         assign prev_word = cell_data[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign next_word = '0;
      end else begin : g_inner_next
         assign next_word = cell_data[g+1];
      end

      ils_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(g)),
         .cmd        (cmd),
         .value_in   (req_data.value),
         .prev_data  (prev_word),
         .next_data  (next_word),
         .data       (cell_data[g]),
         .read_word  (cell_read[g])
      );
   end

   ils_read_tree u_read_tree (
      .clock       (clock),
      .load        (req_accept),
      .words       (cell_read),
      .group_or_ff (group_or)
   );

   // Finish the read OR over the groups
   always_comb begin
      read_or = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         read_or = read_or | group_or[g];
      end
   end

   // Hold the count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Advance the tree stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_status_ff <= status_in;
         s1_count_ff  <= count_in;
      end
   end

   // Advance the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff.read_value <= read_or;
         rsp_data_ff.status     <= s1_status_ff;
         rsp_data_ff.occupancy  <= s1_count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.operation == OP_CLEAR |=> count_ff == '0)
      else $error("clear left entries");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == ST_FULL |->
         rsp_data_ff.occupancy == CNT_W'(DEPTH))
      else $error("full status without a full stack");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == ST_EMPTY |->
         rsp_data_ff.occupancy == '0 && rsp_data_ff.read_value == '0)
      else $error("empty status with data or entries");

endmodule

`default_nettype wire
